// ===== hdl/sol_pkg.sv =====
// Shared types and constants for the self-organizing list core.
`timescale 1ns / 1ps

package sol_pkg;

    localparam int DEFAULT_LIST_DEPTH = 64;
    localparam int DEFAULT_KEY_WIDTH  = 16;
    localparam int COUNT_WIDTH        = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int POLICY_WIDTH       = 2;

    typedef enum logic [POLICY_WIDTH-1:0] {
        POL_NONE      = 2'd0,
        POL_FRONT     = 2'd1,
        POL_TRANSPOSE = 2'd2,
        POL_COUNT     = 2'd3
    } policy_t;

    // Commands from the sequencer to the entry array
    typedef struct packed {
        logic clear;
        logic move;
        logic grow;
    } list_ctl_t;

endpackage

// ===== hdl/self_organizing_list_update_core.sv =====
// A key leaves the queue in the search state, then passes the locate and result states,
// and the result state waits for a free output register; a shift state follows, the
// frequency-count policy adds a rank state first, and a dropped key skips the shift.
// The back-end sequencer over the register entry array takes a new key only when
// idle; a 2-item queue buffers keys ahead. Reset: list empty, policy zero, queue and
// output register empty; a policy write empties the list in the same cycle.
`timescale 1ns / 1ps

module self_organizing_list_update_core #(
    parameter int LIST_DEPTH = sol_pkg::DEFAULT_LIST_DEPTH,
    parameter int KEY_WIDTH  = sol_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sol_pkg::POLICY_WIDTH-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [KEY_WIDTH-1:0]             key,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [$clog2(LIST_DEPTH+1)-1:0]  position,
    output logic                             dropped
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int POS_W = $clog2(LIST_DEPTH + 1);

    sol_pkg::policy_t                policy_reg, policy_next;
    logic                            cfg_wr;
    logic                            q_valid, q_ready;
    logic [KEY_WIDTH-1:0]            q_key;
    sol_pkg::list_ctl_t              list_ctl;
    logic [LIST_DEPTH-1:0]           match;
    logic [POS_W-1:0]                len;
    logic [LIST_DEPTH-1:0]           sel_onehot;
    logic [sol_pkg::COUNT_WIDTH-1:0] sel_count;
    logic [IDX_W-1:0]                rank_idx;
    logic [sol_pkg::COUNT_WIDTH-1:0] rank_count;
    logic [LIST_DEPTH-1:0]           lower;
    logic [IDX_W-1:0]                move_dst, move_src;
    logic [KEY_WIDTH-1:0]            src_key;
    logic [sol_pkg::COUNT_WIDTH-1:0] src_count;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign policy_next = cfg_wr ? sol_pkg::policy_t'(cfg_data) : policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= sol_pkg::POL_NONE;
        end
        else
        begin
            policy_reg <= policy_next;
        end
    end

    sol_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_key   (key),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_key    (q_key)
    );

    sol_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (list_ctl),
        .look_key   (q_key),
        .match      (match),
        .len        (len),
        .sel_onehot (sel_onehot),
        .sel_count  (sel_count),
        .rank_idx   (rank_idx),
        .rank_count (rank_count),
        .lower      (lower),
        .move_dst   (move_dst),
        .move_src   (move_src),
        .src_key    (src_key),
        .src_count  (src_count)
    );

    sol_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .policy     (policy_reg),
        .clear      (cfg_wr),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_key      (q_key),
        .match      (match),
        .len        (len),
        .ctl        (list_ctl),
        .sel_onehot (sel_onehot),
        .sel_count  (sel_count),
        .rank_idx   (rank_idx),
        .rank_count (rank_count),
        .lower      (lower),
        .move_dst   (move_dst),
        .move_src   (move_src),
        .src_key    (src_key),
        .src_count  (src_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .position   (position),
        .dropped    (dropped)
    );

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len <= POS_W'(LIST_DEPTH))
        else $error("list length beyond depth");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (!hit && (position == POS_W'(LIST_DEPTH))))
        else $error("dropped result without a full list");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (position < POS_W'(LIST_DEPTH)))
        else $error("hit position outside the list");

    a_grow_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (list_ctl.move && list_ctl.grow && !list_ctl.clear) |=> (len == $past(len) + 1'b1))
        else $error("append did not extend the list");
`endif

endmodule

// ===== hdl/sol_front.sv =====
// Front end: input register queue that decouples key intake from list updates.
`timescale 1ns / 1ps

module sol_front #(
    parameter int KEY_WIDTH = sol_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_WIDTH-1:0] in_key,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [KEY_WIDTH-1:0] q_key
);

    localparam int PTR_W  = (sol_pkg::QUEUE_DEPTH > 1) ? $clog2(sol_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(sol_pkg::QUEUE_DEPTH + 1);

    logic [KEY_WIDTH-1:0] slot_mem [sol_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 push, pop;

    assign in_ready = (fill_reg != FILL_W'(sol_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_key    = slot_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sol_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sol_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= in_key;
        end
    end

endmodule

// ===== hdl/sol_list.sv =====
// Entry array: keys and counts in registers, parallel compare and neighbor shift.
`timescale 1ns / 1ps

module sol_list #(
    parameter int LIST_DEPTH = sol_pkg::DEFAULT_LIST_DEPTH,
    parameter int KEY_WIDTH  = sol_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sol_pkg::list_ctl_t                  ctl,
    input  logic [KEY_WIDTH-1:0]                look_key,
    output logic [LIST_DEPTH-1:0]               match,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     len,
    input  logic [LIST_DEPTH-1:0]               sel_onehot,
    output logic [sol_pkg::COUNT_WIDTH-1:0]     sel_count,
    input  logic [$clog2(LIST_DEPTH)-1:0]       rank_idx,
    input  logic [sol_pkg::COUNT_WIDTH-1:0]     rank_count,
    output logic [LIST_DEPTH-1:0]               lower,
    input  logic [$clog2(LIST_DEPTH)-1:0]       move_dst,
    input  logic [$clog2(LIST_DEPTH)-1:0]       move_src,
    input  logic [KEY_WIDTH-1:0]                src_key,
    input  logic [sol_pkg::COUNT_WIDTH-1:0]     src_count
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int POS_W = $clog2(LIST_DEPTH + 1);

    logic [KEY_WIDTH-1:0]            keys   [LIST_DEPTH];
    logic [sol_pkg::COUNT_WIDTH-1:0] counts [LIST_DEPTH];
    logic [POS_W-1:0]                len_reg, len_next;

    assign len = len_reg;

    always_comb
    begin
        len_next = len_reg;
        if (ctl.clear)
        begin
            len_next = '0;
        end
        else if (ctl.move && ctl.grow)
        begin
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_entry
        assign match[g] = (POS_W'(g) < len_reg) && (keys[g] == look_key);
        assign lower[g] = (IDX_W'(g) < rank_idx) && (counts[g] < rank_count);

        if (g == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (ctl.move && (move_dst == '0))
                begin
                    keys[g]   <= src_key;
                    counts[g] <= src_count;
                end
            end
        end
        else
        begin : g_body
            // Take the accessed entry at the target, shift the span behind it back one
            always_ff @(posedge clk)
            begin
                if (ctl.move)
                begin
                    if (IDX_W'(g) == move_dst)
                    begin
                        keys[g]   <= src_key;
                        counts[g] <= src_count;
                    end
                    else if ((IDX_W'(g) > move_dst) && (IDX_W'(g) <= move_src))
                    begin
                        keys[g]   <= keys[g-1];
                        counts[g] <= counts[g-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        sel_count = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            sel_count = sel_count | (counts[i] & {sol_pkg::COUNT_WIDTH{sel_onehot[i]}});
        end
    end

endmodule

// ===== hdl/sol_back.sv =====
// Back end: sequencer that locates the key, emits the result and reorders the list.
`timescale 1ns / 1ps

module sol_back #(
    parameter int LIST_DEPTH = sol_pkg::DEFAULT_LIST_DEPTH,
    parameter int KEY_WIDTH  = sol_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sol_pkg::policy_t                    policy,
    input  logic                                clear,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [KEY_WIDTH-1:0]                q_key,
    input  logic [LIST_DEPTH-1:0]               match,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]     len,
    output sol_pkg::list_ctl_t                  ctl,
    output logic [LIST_DEPTH-1:0]               sel_onehot,
    input  logic [sol_pkg::COUNT_WIDTH-1:0]     sel_count,
    output logic [$clog2(LIST_DEPTH)-1:0]       rank_idx,
    output logic [sol_pkg::COUNT_WIDTH-1:0]     rank_count,
    input  logic [LIST_DEPTH-1:0]               lower,
    output logic [$clog2(LIST_DEPTH)-1:0]       move_dst,
    output logic [$clog2(LIST_DEPTH)-1:0]       move_src,
    output logic [KEY_WIDTH-1:0]                src_key,
    output logic [sol_pkg::COUNT_WIDTH-1:0]     src_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     position,
    output logic                                dropped
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int POS_W = $clog2(LIST_DEPTH + 1);
    localparam int CW    = sol_pkg::COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCATE,
        S_PREP,
        S_RANK,
        S_MOVE
    } state_t;

    state_t                state_reg, state_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [LIST_DEPTH-1:0] match_reg, match_next;
    logic [LIST_DEPTH-1:0] onehot_reg, onehot_next;
    logic [POS_W-1:0]      idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic                  drop_reg, drop_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [LIST_DEPTH-1:0] lower_reg, lower_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                  out_drop_reg, out_drop_next;

    logic [LIST_DEPTH-1:0] first_hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      rank_dst;
    logic [CW-1:0]         base_cnt;
    logic                  out_free;

    assign q_ready    = (state_reg == S_IDLE);
    assign sel_onehot = onehot_reg;
    assign rank_idx   = idx_reg[IDX_W-1:0];
    assign rank_count = cnt_reg;
    assign move_src   = idx_reg[IDX_W-1:0];
    assign src_key    = key_reg;
    assign src_count  = cnt_reg;
    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign position   = out_pos_reg;
    assign dropped    = out_drop_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Keep only the earliest match, then encode it
    assign first_hit = match_reg & (~match_reg + 1'b1);

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Earliest entry with a smaller count, else stay put
    always_comb
    begin
        rank_dst = idx_reg[IDX_W-1:0];
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (lower_reg[i])
            begin
                rank_dst = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        case (policy)
            sol_pkg::POL_FRONT:
            begin
                move_dst = '0;
            end
            sol_pkg::POL_TRANSPOSE:
            begin
                move_dst = (idx_reg == '0) ? '0 : idx_reg[IDX_W-1:0] - 1'b1;
            end
            sol_pkg::POL_COUNT:
            begin
                move_dst = rank_dst;
            end
            default:
            begin
                move_dst = idx_reg[IDX_W-1:0];
            end
        endcase
    end

    assign base_cnt = hit_reg ? sel_count : '0;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        match_next     = match_reg;
        onehot_next    = onehot_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        cnt_next       = cnt_reg;
        lower_next     = lower_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_pos_next   = out_pos_reg;
        out_drop_next  = out_drop_reg;
        ctl            = '{clear: clear, move: 1'b0, grow: 1'b0};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    key_next   = q_key;
                    match_next = match;
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE:
            begin
                hit_next    = |match_reg;
                onehot_next = first_hit;
                idx_next    = (|match_reg) ? POS_W'(hit_idx) : len;
                drop_next   = !(|match_reg) && (len == POS_W'(LIST_DEPTH));
                state_next  = S_PREP;
            end
            S_PREP:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_pos_next   = idx_reg;
                    out_drop_next  = drop_reg;
                    if ((policy == sol_pkg::POL_COUNT) && (base_cnt != {CW{1'b1}}))
                    begin
                        cnt_next = base_cnt + 1'b1;
                    end
                    else
                    begin
                        cnt_next = base_cnt;
                    end
                    if (drop_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (policy == sol_pkg::POL_COUNT)
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
            end
            S_RANK:
            begin
                lower_next = lower;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                ctl.move   = 1'b1;
                ctl.grow   = !hit_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= '0;
            match_reg     <= '0;
            onehot_reg    <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            cnt_reg       <= '0;
            lower_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_pos_reg   <= '0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            match_reg     <= match_next;
            onehot_reg    <= onehot_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            drop_reg      <= drop_next;
            cnt_reg       <= cnt_next;
            lower_reg     <= lower_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_pos_reg   <= out_pos_next;
            out_drop_reg  <= out_drop_next;
        end
    end

endmodule
